@@ rtl/core/ngf_pkg.sv @@
// ngf_pkg: shared types, constants and the base-26 power function for the
// n-gram frequency core. No dependencies.
`timescale 1ns / 1ps

package ngf_pkg;

  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned GLEN_W     = 4;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned GEN_W      = 8;
  localparam int unsigned OUT_CODE_W = 57;

  localparam logic [LETTER_W-1:0] MAX_LETTER = 5'd25;
  localparam logic [GLEN_W-1:0]   GLEN_RESET = 4'd4;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [GEN_W-1:0]    GEN_LAST   = 8'hFF;
  localparam logic [GEN_W-1:0]    GEN_FIRST  = 8'h01;
  localparam logic [63:0]         RADIX      = 64'd26;
  localparam logic [63:0]         HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;

  typedef struct packed {
    logic shift;
    logic clear;
  } ngf_cell_ctrl_t;

  function automatic logic [63:0] pow26(input int unsigned e);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned k = 0; k < 14; k++) begin
      if (k < e) begin
        r = r * RADIX;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ngf_cell.sv @@
// ngf_cell: one letter of the sliding window; takes its neighbour's letter
// on every shift while keep_i is high, else zero. Depends on ngf_pkg.
`timescale 1ns / 1ps

module ngf_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ngf_pkg::ngf_cell_ctrl_t       ctrl_i,
  input  logic                          keep_i,
  input  logic [ngf_pkg::LETTER_W-1:0]  digit_i,
  output logic [ngf_pkg::LETTER_W-1:0]  digit_o
);
  import ngf_pkg::*;

  logic [LETTER_W-1:0] digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (ctrl_i.clear) begin
      digit_q <= '0;
    end else if (ctrl_i.shift) begin
      digit_q <= keep_i ? digit_i : '0;
    end
  end

  assign digit_o = digit_q;

endmodule

@@ rtl/core/ngram_frequency_max_core.sv @@
// ngram_frequency_max_core: rolling base-26 window over a row of letter cells,
// hashed count table with generation tags, and leader tracking.
// Depends on ngf_pkg and ngf_cell.
//
//   channel   direction  handshake                     payload
//   config    in         gram_len_we_i                 gram_len_i
//   letters   in         in_valid_i / in_ready_o       letter_i, last_letter_i
//   result    out        out_valid_o / out_ready_i     best_code_o, best_count_o,
//                                                      result_length_o, table_overflow_o
//
// Normally a letter first updates the window code (subtract the dropped letter,
// then multiply and add the new one); a letter that completes no gram then goes
// to the finish step. Otherwise come the hash (products, then slot), each table
// probe (registered read, then update), the leader compare and the finish
// step. A non power-of-two table depth adds a remainder by repeated
// subtraction. The first letter after a gram_len write rebuilds the window
// code instead, one cell a cycle. After reset, and whenever the generation tag
// wraps, a clearing pass over all TABLE_DEPTH entries runs with in_ready_o low.
// A waiting result stalls only the last letter of the next string.
`timescale 1ns / 1ps

module ngram_frequency_max_core #(
  parameter int unsigned MAX_GRAM    = 12,
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_PROBES  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            gram_len_we_i,
  input  logic [ngf_pkg::GLEN_W-1:0]      gram_len_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ngf_pkg::LETTER_W-1:0]    letter_i,
  input  logic                            last_letter_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ngf_pkg::OUT_CODE_W-1:0]  best_code_o,
  output logic [ngf_pkg::COUNT_W-1:0]     best_count_o,
  output logic [ngf_pkg::GLEN_W-1:0]      result_length_o,
  output logic                            table_overflow_o
);
  import ngf_pkg::*;

  localparam int unsigned CODE_W  = (MAX_GRAM * 47 + 9) / 10;
  localparam int unsigned AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W   = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
  localparam int unsigned P_W     = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int unsigned LS_W    = $clog2(MAX_GRAM + 2);
  localparam int unsigned MEM_W   = GEN_W + CODE_W + COUNT_W;
  localparam bit          IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int unsigned KS      = 32 - $clog2(TABLE_DEPTH + 1);
  localparam int unsigned K_W     = 5;

  localparam logic [LS_W-1:0]  LS_MAX     = LS_W'(MAX_GRAM + 1);
  localparam logic [AW-1:0]    ADDR_LAST  = AW'(TABLE_DEPTH - 1);
  localparam logic [P_W-1:0]   PROBE_LAST = P_W'(MAX_PROBES - 1);
  localparam logic [IDX_W-1:0] CELL_LAST  = IDX_W'(MAX_GRAM - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUB  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_HOR  = 4'd3;
  localparam logic [3:0] S_HASH = 4'd4;
  localparam logic [3:0] S_SLOT = 4'd5;
  localparam logic [3:0] S_REM  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_EV   = 4'd8;
  localparam logic [3:0] S_LEAD = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;
  localparam logic [3:0] S_CLR  = 4'd11;

  logic [3:0]          st_q;
  logic [GLEN_W-1:0]   gram_len_q;
  logic                resync_q;
  logic [CODE_W-1:0]   code_q;
  logic [CODE_W-1:0]   drop_q;
  logic [CODE_W-1:0]   diff_q;
  logic [CODE_W-1:0]   acc_q;
  logic [IDX_W-1:0]    j_q;
  logic [LETTER_W-1:0] ch_q;
  logic                last_q;
  logic [LS_W-1:0]     lseen_q;
  logic [31:0]         p00_hi_q;
  logic [31:0]         p01_q;
  logic [31:0]         p10_q;
  logic [31:0]         rem_q;
  logic [K_W-1:0]      k_q;
  logic [AW-1:0]       idx_q;
  logic [P_W-1:0]      p_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [GEN_W-1:0]    gen_q;
  logic [CODE_W-1:0]   lead_code_q;
  logic [COUNT_W-1:0]  lead_cnt_q;
  logic                ovf_q;
  logic [AW-1:0]       clr_q;
  logic                out_valid_q;
  logic [OUT_CODE_W-1:0] out_code_q;
  logic [COUNT_W-1:0]  out_cnt_q;
  logic [GLEN_W-1:0]   out_len_q;
  logic                out_ovf_q;

  logic [MEM_W-1:0]    mem [TABLE_DEPTH];
  logic [MEM_W-1:0]    rd_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [MEM_W-1:0]    mem_wd;

  logic [GLEN_W-1:0]   g_eff;
  logic [IDX_W-1:0]    gi;
  logic [LETTER_W-1:0] ch;
  logic                accept;
  logic                slot_free;
  logic                finish;
  logic                counted;
  logic                short_str;
  ngf_cell_ctrl_t      cell_ctrl;

  logic [LETTER_W-1:0] digit_w [MAX_GRAM];
  logic [CODE_W-1:0]   pow_w   [MAX_GRAM];

  logic [63:0]         key64;
  logic [63:0]         p00;
  logic [31:0]         hash_hi;
  logic [63:0]         sub_w;
  logic [31:0]         rem_next;
  logic [CODE_W-1:0]   acc_next;
  logic [GEN_W-1:0]    rd_gen;
  logic [CODE_W-1:0]   rd_key;
  logic [COUNT_W-1:0]  rd_cnt;
  logic [COUNT_W-1:0]  cnt_inc;

  always_comb begin
    if (gram_len_q == '0) begin
      g_eff = GLEN_W'(1);
    end else if (gram_len_q > GLEN_W'(MAX_GRAM)) begin
      g_eff = GLEN_W'(MAX_GRAM);
    end else begin
      g_eff = gram_len_q;
    end
  end

  assign gi        = IDX_W'(g_eff - GLEN_W'(1));
  assign ch        = (letter_i > MAX_LETTER) ? MAX_LETTER : letter_i;
  assign in_ready_o = (st_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign finish    = (st_q == S_DONE) && last_q && slot_free;
  assign counted   = GLEN_W'(lseen_q) >= g_eff;
  assign short_str = GLEN_W'(lseen_q) <= g_eff;

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = finish;

  for (genvar i = 0; i < MAX_GRAM; i++) begin : g_cells
    logic [LETTER_W-1:0] nb;
    if (i == 0) begin : g_head
      assign nb = ch;
    end else begin : g_body
      assign nb = digit_w[i-1];
    end
    assign pow_w[i] = CODE_W'(pow26(i));
    ngf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .keep_i  (GLEN_W'(i) < g_eff),
      .digit_i (nb),
      .digit_o (digit_w[i])
    );
  end

  assign key64    = 64'(code_q);
  assign p00      = {32'b0, key64[31:0]} * {32'b0, HASH_MULT[31:0]};
  assign hash_hi  = p00_hi_q + p01_q + p10_q;
  assign sub_w    = 64'(TABLE_DEPTH) << k_q;
  assign rem_next = (64'(rem_q) >= sub_w) ? (rem_q - 32'(sub_w)) : rem_q;
  assign acc_next = CODE_W'(acc_q * CODE_W'(RADIX)) + CODE_W'(digit_w[j_q]);

  assign rd_gen  = rd_q[MEM_W-1 -: GEN_W];
  assign rd_key  = rd_q[COUNT_W +: CODE_W];
  assign rd_cnt  = rd_q[COUNT_W-1:0];
  assign cnt_inc = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = {gen_q, code_q, COUNT_W'(1)};
    if (st_q == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (st_q == S_EV) begin
      if (rd_gen != gen_q) begin
        mem_we = 1'b1;
      end else if (rd_key == code_q) begin
        mem_we = 1'b1;
        mem_wd = {gen_q, code_q, cnt_inc};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (st_q == S_RD) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLR;
      gram_len_q  <= GLEN_RESET;
      resync_q    <= 1'b0;
      code_q      <= '0;
      drop_q      <= '0;
      diff_q      <= '0;
      acc_q       <= '0;
      j_q         <= '0;
      ch_q        <= '0;
      last_q      <= 1'b0;
      lseen_q     <= '0;
      p00_hi_q    <= '0;
      p01_q       <= '0;
      p10_q       <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      p_q         <= '0;
      cnt_q       <= '0;
      gen_q       <= GEN_FIRST;
      lead_code_q <= '0;
      lead_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
      out_cnt_q   <= '0;
      out_len_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (gram_len_we_i) begin
        gram_len_q <= gram_len_i;
        resync_q   <= 1'b1;
      end
      if (out_ready_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (accept) begin
            ch_q   <= ch;
            last_q <= last_letter_i;
            drop_q <= CODE_W'(digit_w[gi] * pow_w[gi]);
            if (lseen_q != LS_MAX) begin
              lseen_q <= lseen_q + LS_W'(1);
            end
            acc_q <= '0;
            j_q   <= CELL_LAST;
            st_q  <= resync_q ? S_HOR : S_SUB;
          end
        end
        S_SUB: begin
          diff_q <= code_q - drop_q;
          st_q   <= S_MUL;
        end
        S_MUL: begin
          code_q <= CODE_W'(diff_q * CODE_W'(RADIX)) + CODE_W'(ch_q);
          st_q   <= counted ? S_HASH : S_DONE;
        end
        S_HOR: begin
          if (j_q == '0) begin
            code_q   <= acc_next;
            resync_q <= 1'b0;
            st_q     <= counted ? S_HASH : S_DONE;
          end else begin
            acc_q <= acc_next;
            j_q   <= j_q - IDX_W'(1);
          end
        end
        S_HASH: begin
          p00_hi_q <= p00[63:32];
          p01_q    <= key64[31:0] * HASH_MULT[63:32];
          p10_q    <= key64[63:32] * HASH_MULT[31:0];
          st_q     <= S_SLOT;
        end
        S_SLOT: begin
          p_q <= '0;
          if (IS_POW2) begin
            idx_q <= hash_hi[AW-1:0];
            st_q  <= S_RD;
          end else begin
            rem_q <= hash_hi;
            k_q   <= K_W'(KS);
            st_q  <= S_REM;
          end
        end
        S_REM: begin
          rem_q <= rem_next;
          if (k_q == '0) begin
            idx_q <= rem_next[AW-1:0];
            st_q  <= S_RD;
          end else begin
            k_q <= k_q - K_W'(1);
          end
        end
        S_RD: begin
          st_q <= S_EV;
        end
        S_EV: begin
          if (rd_gen != gen_q) begin
            cnt_q <= COUNT_W'(1);
            st_q  <= S_LEAD;
          end else if (rd_key == code_q) begin
            cnt_q <= cnt_inc;
            st_q  <= S_LEAD;
          end else if (p_q == PROBE_LAST) begin
            ovf_q <= 1'b1;
            st_q  <= S_DONE;
          end else begin
            idx_q <= (idx_q == ADDR_LAST) ? '0 : idx_q + AW'(1);
            p_q   <= p_q + P_W'(1);
            st_q  <= S_RD;
          end
        end
        S_LEAD: begin
          if (cnt_q > lead_cnt_q || (cnt_q == lead_cnt_q && code_q < lead_code_q)) begin
            lead_cnt_q  <= cnt_q;
            lead_code_q <= code_q;
          end
          st_q <= S_DONE;
        end
        S_DONE: begin
          if (!last_q) begin
            st_q <= S_IDLE;
          end else if (slot_free) begin
            out_valid_q <= 1'b1;
            if (short_str) begin
              out_code_q <= OUT_CODE_W'(code_q);
              out_cnt_q  <= '0;
              out_len_q  <= GLEN_W'(lseen_q);
              out_ovf_q  <= 1'b0;
            end else begin
              out_code_q <= OUT_CODE_W'(lead_code_q);
              out_cnt_q  <= lead_cnt_q;
              out_len_q  <= g_eff;
              out_ovf_q  <= ovf_q;
            end
            code_q      <= '0;
            lseen_q     <= '0;
            lead_code_q <= '0;
            lead_cnt_q  <= '0;
            ovf_q       <= 1'b0;
            if (gen_q == GEN_LAST) begin
              gen_q <= GEN_FIRST;
              clr_q <= '0;
              st_q  <= S_CLR;
            end else begin
              gen_q <= gen_q + GEN_W'(1);
              st_q  <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          if (clr_q == ADDR_LAST) begin
            st_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign best_code_o      = out_code_q;
  assign best_count_o     = out_cnt_q;
  assign result_length_o  = out_len_q;
  assign table_overflow_o = out_ovf_q;

endmodule
